### hw/rtl/tpps_pkg.sv
// Shared types and constants for the timer prescaler and period solver.
`default_nettype none
package tpps_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned DIV_CNT_BITS = 6;
	localparam int unsigned NARROW_SHIFT = 16;
	localparam logic [32:0] NARROW_PERIOD_MAX = 33'h0_0000_FFFF;
	localparam logic [15:0] GRANULARITY_RESET = 16'd255;

	typedef struct packed {
		logic start;
		logic big;
		logic [WORD_BITS-1:0] dividend;
		logic [WORD_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic [WORD_BITS-1:0] quotient;
	} div_rsp_t;

endpackage
`default_nettype wire

### hw/rtl/tpps_mul.sv
// Shift-and-add multiplier, one multiplier bit per cycle, keeping the low 32 bits and flagging overflow.
`default_nettype none
module tpps_mul #(
	parameter int unsigned MW = 17
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [31:0]   multiplicand,
	input  wire logic [MW-1:0] multiplier,
	output logic               done,
	output logic [31:0]        product,
	output logic               ovf
);
	import tpps_pkg::*;

	localparam int unsigned CW = $clog2(MW + 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] mr_q;
	logic [31:0]   acc_q;
	logic          ovf_q;
	logic [33:0]   sum;

	always_comb begin
		sum = {1'b0, acc_q, 1'b0} + (mr_q[MW-1] ? {2'b00, multiplicand} : 34'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(MW);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mr_q <= multiplier;
			acc_q <= '0;
			ovf_q <= 1'b0;
		end else if (busy_q && cnt_q != '0) begin
			mr_q <= {mr_q[MW-2:0], 1'b0};
			acc_q <= sum[WORD_BITS-1:0];
			ovf_q <= ovf_q | (sum[33:32] != 2'b00);
		end
	end

	assign done = busy_q && cnt_q == '0;
	assign product = acc_q;
	assign ovf = ovf_q;

endmodule
`default_nettype wire

### hw/rtl/tpps_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module tpps_div (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tpps_pkg::div_req_t req,
	output tpps_pkg::div_rsp_t      rsp
);
	import tpps_pkg::*;

	logic                    busy_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [WORD_BITS-1:0]    nq_q;
	logic [WORD_BITS-1:0]    rem_q;
	logic [WORD_BITS-1:0]    d_q;
	logic                    big_q;
	logic [WORD_BITS:0]      trial;
	logic                    fits;

	always_comb begin
		trial = {rem_q, nq_q[WORD_BITS-1]};
		fits = !big_q && trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= DIV_CNT_BITS'(DIV_STEPS);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - DIV_CNT_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			nq_q <= req.dividend;
			rem_q <= '0;
			d_q <= req.divisor;
			big_q <= req.big;
		end else if (busy_q && cnt_q != '0) begin
			nq_q <= {nq_q[WORD_BITS-2:0], fits};
			rem_q <= fits ? WORD_BITS'(trial - {1'b0, d_q}) : trial[WORD_BITS-1:0];
		end
	end

	assign rsp.done = busy_q && cnt_q == '0;
	assign rsp.quotient = nq_q;

endmodule
`default_nettype wire

### hw/rtl/timer_prescaler_period_solver_core.sv
// Top level of the timer prescaler and period solver with its sequencer.
//
// Channel   Direction  Handshake               Word
// in        input      in_valid / in_ready     ref_clock_hz, target_freq_hz, wide_counter
// out       output     out_valid / out_ready   status, prescaler, period
// cfg       input      cfg_we                  cfg_wdata (min_granularity)
//
// From acceptance to out_valid a word makes two MW-step passes through the bit-serial multiplier
// and two 32-step passes through the divider, in turn, MW = max(PRESCALER_BITS + 1, 16); then the
// result is loaded into the output register, and the sequencer returns to idle for the next word.
// An error found early skips the remaining passes.
// Reset clears the sequencer, the output valid flag and sets min_granularity to 255.
// A new word is taken while a finished result waits; the sequencer holds in its last
// state only when the output register is still full.
`default_nettype none
module timer_prescaler_period_solver_core #(
	parameter int unsigned PRESCALER_BITS = 16,
	parameter int unsigned WIDE_PERIOD_BITS = 32
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [31:0]               ref_clock_hz,
	input  wire logic [31:0]               target_freq_hz,
	input  wire logic                      wide_counter,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic                           status,
	output logic [PRESCALER_BITS-1:0]      prescaler,
	output logic [31:0]                    period,
	input  wire logic                      cfg_we,
	input  wire logic [15:0]               cfg_wdata
);
	import tpps_pkg::*;

	localparam int unsigned MW = (PRESCALER_BITS + 1 > 16) ? PRESCALER_BITS + 1 : 16;
	localparam logic [32:0] MAX_PRESC = 33'((64'd1 << PRESCALER_BITS) - 64'd1);
	localparam logic [32:0] WIDE_PERIOD_MAX = 33'((64'd1 << WIDE_PERIOD_BITS) - 64'd1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_GMUL = 6'b000010,
		S_DIV1 = 6'b000100,
		S_PMUL = 6'b001000,
		S_DIV2 = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [15:0]               gran_q;
	logic [31:0]               ref_q;
	logic [31:0]               freq_q;
	logic                      wide_q;
	logic                      err_q;
	logic [PRESCALER_BITS-1:0] presc_q;
	logic [31:0]               per_q;
	logic                      out_valid_q;
	logic                      status_q;
	logic [PRESCALER_BITS-1:0] prescaler_q;
	logic [31:0]               period_q;

	logic           accept;
	logic           mul_start;
	logic [MW-1:0]  mul_mr;
	logic           mul_done;
	logic [31:0]    mul_prod;
	logic           mul_ovf;
	div_req_t       dreq;
	div_rsp_t       drsp;
	logic [63:0]    div1_d;
	logic [32:0]    maxper;
	logic [32:0]    quot_m1;
	logic           out_free;

	assign accept = in_valid && in_ready;
	assign in_ready = state_q == S_IDLE;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		if (wide_q) begin
			div1_d = ({32'd0, freq_q} << WIDE_PERIOD_BITS) + {32'd0, freq_q};
			maxper = WIDE_PERIOD_MAX;
		end else begin
			div1_d = ({32'd0, freq_q} << NARROW_SHIFT) + {32'd0, freq_q};
			maxper = NARROW_PERIOD_MAX;
		end
		quot_m1 = {1'b0, drsp.quotient} - 33'd1;
	end

	always_comb begin
		mul_start = 1'b0;
		mul_mr = MW'(gran_q == 16'd0 ? 16'd1 : gran_q);
		dreq.start = 1'b0;
		dreq.big = 1'b0;
		dreq.dividend = ref_q;
		dreq.divisor = div1_d[31:0];
		case (state_q)
			S_IDLE: begin
				mul_start = accept;
			end
			S_GMUL: begin
				dreq.big = |div1_d[63:32];
				dreq.start = mul_done && !(freq_q == 32'd0 || mul_ovf || mul_prod > ref_q);
			end
			S_DIV1: begin
				mul_mr = MW'(drsp.quotient[PRESCALER_BITS-1:0]) + MW'(1);
				mul_start = drsp.done && {1'b0, drsp.quotient} <= MAX_PRESC;
			end
			S_PMUL: begin
				dreq.big = mul_ovf;
				dreq.divisor = mul_prod;
				dreq.start = mul_done;
			end
			default: begin
			end
		endcase
	end

	tpps_mul #(
		.MW(MW)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(mul_start),
		.multiplicand(freq_q),
		.multiplier(mul_mr),
		.done(mul_done),
		.product(mul_prod),
		.ovf(mul_ovf)
	);

	tpps_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(dreq),
		.rsp(drsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			gran_q <= GRANULARITY_RESET;
		end else begin
			if (cfg_we) begin
				gran_q <= cfg_wdata;
			end
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_GMUL;
					end
				end
				S_GMUL: begin
					if (mul_done) begin
						state_q <= dreq.start ? S_DIV1 : S_FIN;
					end
				end
				S_DIV1: begin
					if (drsp.done) begin
						state_q <= mul_start ? S_PMUL : S_FIN;
					end
				end
				S_PMUL: begin
					if (mul_done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (drsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ref_q <= ref_clock_hz;
					freq_q <= target_freq_hz;
					wide_q <= wide_counter;
					err_q <= 1'b0;
				end
			end
			S_GMUL: begin
				if (mul_done && !dreq.start) begin
					err_q <= 1'b1;
				end
			end
			S_DIV1: begin
				if (drsp.done) begin
					presc_q <= drsp.quotient[PRESCALER_BITS-1:0];
					if (!mul_start) begin
						err_q <= 1'b1;
					end
				end
			end
			S_DIV2: begin
				if (drsp.done) begin
					per_q <= quot_m1[31:0];
					if (drsp.quotient == 32'd0 || quot_m1 > maxper) begin
						err_q <= 1'b1;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					status_q <= err_q;
					prescaler_q <= err_q ? '0 : presc_q;
					period_q <= err_q ? 32'd0 : per_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign prescaler = prescaler_q;
	assign period = period_q;

endmodule
`default_nettype wire

### sim/timer_solution_checker.sv
// Checker that predicts each prescaler and period solution and compares it with the result.
module timer_solution_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [31:0] ref_clock_hz,
	input  wire logic [31:0] target_freq_hz,
	input  wire logic        wide_counter,
	input  wire logic        out_valid,
	input  wire logic        out_ready,
	input  wire logic        status,
	input  wire logic [15:0] prescaler,
	input  wire logic [31:0] period,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	output int unsigned      mismatches,
	output int unsigned      awaiting
);
	timeunit 1ns;
	timeprecision 1ps;
	import tpps_pkg::*;

	typedef struct packed {
		logic        status;
		logic [15:0] prescaler;
		logic [31:0] period;
	} solution_t;

	solution_t expected_solutions[$];
	logic [15:0] granularity;

	function automatic solution_t solve_prescaler_period(logic [31:0] ref_hz, logic [31:0] freq_hz,
		logic wide, logic [15:0] gran_reg);
		logic [63:0] gran;
		logic [63:0] top_period;
		logic [63:0] presc;
		logic [63:0] quot;
		solution_t sol;
		gran = (gran_reg == 16'd0) ? 64'd1 : 64'(gran_reg);
		top_period = wide ? 64'hFFFF_FFFF : 64'(NARROW_PERIOD_MAX);
		sol = '0;
		if (freq_hz == 32'd0 || 64'(freq_hz) > 64'(ref_hz) / gran) begin
			sol.status = 1'b1;
		end else begin
			presc = 64'(ref_hz) / (64'(freq_hz) * (top_period + 64'd2));
			if (presc > 64'hFFFF) begin
				sol.status = 1'b1;
			end else begin
				quot = 64'(ref_hz) / (64'(freq_hz) * (presc + 64'd1));
				if (quot == 64'd0 || quot - 64'd1 > top_period) begin
					sol.status = 1'b1;
				end else begin
					sol.prescaler = presc[15:0];
					sol.period = 32'(quot - 64'd1);
				end
			end
		end
		return sol;
	endfunction

	task automatic flag_mismatch(string what, solution_t want, solution_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t %s: expected status %0d prescaler %0d period %0d,",
				$realtime, what, want.status, want.prescaler, want.period,
				" got status %0d prescaler %0d period %0d",
				got.status, got.prescaler, got.period);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		solution_t want;
		solution_t got;
		if (!arst_n) begin
			granularity = GRANULARITY_RESET;
			expected_solutions.delete();
			mismatches = 0;
			awaiting <= 0;
		end else begin
			if (out_valid && out_ready) begin
				got = '{status: status, prescaler: prescaler, period: period};
				if (expected_solutions.size() == 0) begin
					flag_mismatch("result with none expected", 'x, got);
				end else begin
					want = expected_solutions.pop_front();
					if (got.status !== want.status || got.prescaler !== want.prescaler
						|| got.period !== want.period) begin
						flag_mismatch("wrong result", want, got);
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_solutions.push_back(solve_prescaler_period(ref_clock_hz, target_freq_hz,
					wide_counter, granularity));
			end
			if (cfg_we) begin
				granularity = cfg_wdata;
			end
			awaiting <= expected_solutions.size();
		end
	end

endmodule

### sim/timer_prescaler_period_solver_core_tb.sv
// Testbench top for the timer prescaler and period solver: stimulus, register phases and verdict.
module timer_prescaler_period_solver_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tpps_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [31:0] ref_clock_hz = '0;
	logic [31:0] target_freq_hz = '0;
	logic        wide_counter = 1'b0;
	logic        out_ready = 1'b0;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic        in_ready;
	logic        out_valid;
	logic        status;
	logic [15:0] prescaler;
	logic [31:0] period;

	int unsigned mismatches;
	int unsigned awaiting;
	logic        steady = 1'b0;
	logic [15:0] cur_gran = GRANULARITY_RESET;

	timer_prescaler_period_solver_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ref_clock_hz(ref_clock_hz),
		.target_freq_hz(target_freq_hz),
		.wide_counter(wide_counter),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.prescaler(prescaler),
		.period(period),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	timer_solution_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.ref_clock_hz(ref_clock_hz),
		.target_freq_hz(target_freq_hz),
		.wide_counter(wide_counter),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.prescaler(prescaler),
		.period(period),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.awaiting(awaiting)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 34);
	end

	task automatic send_word(logic [31:0] ref_hz, logic [31:0] freq_hz, logic wide);
		if (!steady && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 34);
		end
		in_valid <= 1'b1;
		ref_clock_hz <= ref_hz;
		target_freq_hz <= freq_hz;
		wide_counter <= wide;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (awaiting != 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic program_granularity(logic [15:0] value);
		settle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		cur_gran = value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_word();
		logic [31:0] ref_hz;
		logic [31:0] freq_hz;
		logic [31:0] limit;
		case ($urandom_range(0, 7))
			0: ref_hz = $urandom_range(0, 1000);
			1: ref_hz = '1;
			default: ref_hz = $urandom();
		endcase
		limit = ref_hz / ((cur_gran == 16'd0) ? 32'd1 : 32'(cur_gran));
		case ($urandom_range(0, 9))
			0, 1: freq_hz = $urandom();
			2: freq_hz = limit;
			3: freq_hz = limit + 32'd1;
			4: freq_hz = (limit == 0) ? 32'd1 : $urandom_range(1, limit);
			5, 6: begin
				freq_hz = limit >> $urandom_range(0, 31);
				if (freq_hz == 0) begin
					freq_hz = 32'd1;
				end
			end
			7, 8: freq_hz = $urandom_range(1, 2000);
			default: freq_hz = '0;
		endcase
		send_word(ref_hz, freq_hz, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// The reset granularity of 255 is checked first.
		send_word(32'd1_000_000, 32'd0, 1'b0);
		send_word(32'd0, 32'd1, 1'b0);
		send_word(32'd0, 32'd0, 1'b1);
		send_word(32'hFFFF_FFFF, 32'd1, 1'b0);
		send_word(32'hFFFF_FFFF, 32'd1, 1'b1);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_word(32'd255_000, 32'd1000, 1'b0);
		send_word(32'd255_000, 32'd1001, 1'b0);
		send_word(32'd72_000_000, 32'd1000, 1'b0);
		send_word(32'd72_000_000, 32'd1, 1'b1);
		send_word(32'hFFFF_FFFF, 32'd16_843_009, 1'b0);

		program_granularity(16'd1);
		send_word(32'd1, 32'd1, 1'b0);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		send_word(32'h8000_0000, 32'd1, 1'b0);
		send_word(32'd65_536, 32'd1, 1'b0);
		send_word(32'd65_537, 32'd1, 1'b0);

		program_granularity(16'hFFFF);
		send_word(32'hFFFF_FFFF, 32'd65_537, 1'b0);
		send_word(32'hFFFF_FFFF, 32'd65_538, 1'b1);

		// A granularity of zero behaves as one.
		program_granularity(16'd0);
		send_word(32'd5, 32'd5, 1'b0);
		send_word(32'd5, 32'd6, 1'b1);
		send_word(32'd0, 32'd0, 1'b1);

		for (int phase = 0; phase < 7; phase++) begin
			case (phase)
				0: program_granularity(GRANULARITY_RESET);
				1: program_granularity(16'd1);
				2: program_granularity(16'hFFFF);
				3: program_granularity(16'd0);
				default: program_granularity(16'($urandom_range(2, 65534)));
			endcase
			steady <= (phase == 2);
			repeat (100) random_word();
		end
		steady <= 1'b0;

		settle();
		if (mismatches == 0 && awaiting == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#20_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
